FILE: hw/rtl/rpn_stack_evaluator_top_macros.svh
// Assertion helpers for the RPN evaluator.
`ifndef RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define RSE_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define RSE_CHECK_AFTER(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rse_pkg.sv
package rse_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_NOTONE   = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_SKIP = 2'd0,
    K_PUSH = 2'd1,
    K_OP   = 2'd2,
    K_BAD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/rse_in_if.sv
interface rse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

FILE: hw/rtl/rse_out_if.sv
interface rse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

FILE: hw/rtl/rse_ram.sv
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rse_front.sv
module rse_front (
  input  logic          clk,
  input  logic          rst,
  rse_in_if.sink        expr,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output rse_pkg::cmd_t cmd
);
  import rse_pkg::*;

  function automatic cmd_t classify(input logic [7:0] sym, input logic last);
    cmd_t       c;
    logic [7:0] diff;
    diff    = sym - CH_ZERO;
    c.kind  = K_BAD;
    c.op    = OP_ADD;
    c.digit = diff[3:0];
    c.last  = last;
    if (sym == CH_SPACE) begin
      c.kind = K_SKIP;
    end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
      c.kind = K_PUSH;
    end else if (sym == CH_PLUS) begin
      c.kind = K_OP;
      c.op   = OP_ADD;
    end else if (sym == CH_MINUS) begin
      c.kind = K_OP;
      c.op   = OP_SUB;
    end else if (sym == CH_STAR) begin
      c.kind = K_OP;
      c.op   = OP_MUL;
    end else if (sym == CH_SLASH) begin
      c.kind = K_OP;
      c.op   = OP_DIV;
    end
    return c;
  endfunction

  cmd_t cls;
  logic keep;
  logic take;

  assign cls        = classify(expr.symbol, expr.last);
  // a space that does not close the expression has no effect downstream
  assign keep       = !(cls.kind == K_SKIP && !cls.last);
  assign expr.ready = !cmd_valid || cmd_ready;
  assign take       = expr.valid && expr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cls;
    end
  end

endmodule

FILE: hw/rtl/rse_fifo.sv
module rse_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rse_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output rse_pkg::cmd_t out_cmd
);
  import rse_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   level;
  logic               push;
  logic               pop;

  assign in_ready  = level != (Q_PTR_W + 1)'(Q_DEPTH);
  assign out_valid = level != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

FILE: hw/rtl/rse_div.sv
module rse_div (
  input  logic              clk,
  input  logic              rst,
  input  rse_pkg::div_req_t req,
  output rse_pkg::div_rsp_t rsp
);
  import rse_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [STEP_W-1:0] cnt;
  logic              neg;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] un;
  logic [DATA_W-1:0] ud;

  assign un     = req.num[DATA_W-1] ? (DATA_W)'(0) - req.num : req.num;
  assign ud     = req.den[DATA_W-1] ? (DATA_W)'(0) - req.den : req.den;
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= un;
      dvs <= ud;
      neg <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? (DATA_W)'(0) - quo : quo;

endmodule

FILE: hw/rtl/rse_back.sv
module rse_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rse_pkg::cmd_t     cmd,
  output rse_pkg::div_req_t div_req,
  input  rse_pkg::div_rsp_t div_rsp,
  rse_out_if.source         result
);
  import rse_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_DISPATCH = 4'b0001,
    S_REFILL   = 4'b0010,
    S_DIV      = 4'b0100,
    S_EMIT     = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [DATA_W-1:0] tos, tos_next;
  logic [DATA_W-1:0] nos, nos_next;
  logic [CW-1:0]     count, count_next;
  status_t           err, err_next;
  logic              last_pend, last_pend_next;
  logic              out_valid, out_valid_next;
  logic [DATA_W-1:0] out_value, out_value_next;
  status_t           out_status, out_status_next;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CW-1:0]     cnt_m2;
  logic [CW-1:0]     cnt_m3;
  logic [DATA_W-1:0] alu;
  logic              slot_free;

  // the top two values live in tos/nos; deeper entries in the RAM
  assign cnt_m2    = count - CW'(2);
  assign cnt_m3    = count - CW'(3);
  assign ram_waddr = cnt_m2[AW-1:0];
  assign ram_raddr = cnt_m3[AW-1:0];
  assign slot_free = !out_valid || result.ready;

  always_comb begin
    unique case (cmd.op)
      OP_ADD:  alu = nos + tos;
      OP_SUB:  alu = nos - tos;
      OP_MUL:  alu = nos * tos;
      OP_DIV:  alu = nos;
      default: alu = nos;
    endcase
  end

  rse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (nos),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    tos_next        = tos;
    nos_next        = nos;
    count_next      = count;
    err_next        = err;
    last_pend_next  = last_pend;
    out_valid_next  = out_valid && !result.ready;
    out_value_next  = out_value;
    out_status_next = out_status;
    cmd_ready       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    div_req.start   = 1'b0;
    div_req.num     = nos;
    div_req.den     = tos;

    unique case (state)
      S_DISPATCH: begin
        if (cmd_valid) begin
          cmd_ready      = 1'b1;
          last_pend_next = cmd.last;
          state_next     = cmd.last ? S_EMIT : S_DISPATCH;
          if (err == ST_OK) begin
            unique case (cmd.kind)
              K_SKIP: begin
              end
              K_BAD: begin
                err_next = ST_BADCHAR;
              end
              K_PUSH: begin
                if (count >= CW'(STACK_DEPTH)) begin
                  err_next = ST_OVERFLOW;
                end else begin
                  ram_we     = count >= CW'(2);
                  nos_next   = tos;
                  tos_next   = {{(DATA_W - 4){1'b0}}, cmd.digit};
                  count_next = count + 1'b1;
                end
              end
              K_OP: begin
                if (count < CW'(2)) begin
                  err_next = ST_FEW;
                end else if (cmd.op == OP_DIV) begin
                  if (tos == '0) begin
                    err_next = ST_DIVZERO;
                  end else begin
                    div_req.start = 1'b1;
                    ram_re        = 1'b1;
                    state_next    = S_DIV;
                  end
                end else begin
                  tos_next   = alu;
                  count_next = count - 1'b1;
                  ram_re     = 1'b1;
                  state_next = S_REFILL;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_REFILL: begin
        nos_next   = ram_rdata;
        state_next = last_pend ? S_EMIT : S_DISPATCH;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_next   = div_rsp.quotient;
          nos_next   = ram_rdata;
          count_next = count - 1'b1;
          state_next = last_pend ? S_EMIT : S_DISPATCH;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          if (err != ST_OK) begin
            out_status_next = err;
            out_value_next  = '0;
          end else if (count != CW'(1)) begin
            out_status_next = ST_NOTONE;
            out_value_next  = '0;
          end else begin
            out_status_next = ST_OK;
            out_value_next  = tos;
          end
          count_next = '0;
          err_next   = ST_OK;
          state_next = S_DISPATCH;
        end
      end
      default: begin
        state_next = S_DISPATCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_DISPATCH;
      count     <= '0;
      err       <= ST_OK;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      err       <= err_next;
      last_pend <= last_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tos        <= tos_next;
    nos        <= nos_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

  assign result.valid  = out_valid;
  assign result.value  = $signed(out_value);
  assign result.status = out_status;

endmodule

FILE: hw/rtl/rpn_stack_evaluator_top.sv
// RPN evaluator: one ASCII character per transaction on expr, last set on the final
// character; one result per expression on result. The front stage classifies a
// character and registers it; a four-entry queue decouples it from the execution
// stage. In execution, a digit, a space or a bad character is handled at dispatch;
// + - * dispatch and then refill next-of-stack from the stack RAM's registered read;
// / dispatches, runs the 32-step serial divider and takes the quotient; the last
// character also passes a state that posts the result. The execution stage takes
// no new character while a division runs. Items after the first error are consumed
// at one per cycle. No clearing pass is needed after reset.
`include "rpn_stack_evaluator_top_macros.svh"

module rpn_stack_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  rse_in_if.sink    expr,
  rse_out_if.source result
);
  import rse_pkg::*;

  logic     f_valid;
  logic     f_ready;
  cmd_t     f_cmd;
  logic     q_valid;
  logic     q_ready;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  rse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .expr      (expr),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  rse_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  rse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .result    (result)
  );

  rse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `RSE_CHECK(a_err_value_zero, clk, rst, result.valid && result.status != ST_OK, result.value == 0, "error result carries nonzero value")
  `RSE_CHECK_AFTER(a_div_latency, clk, rst, div_req.start, 33, div_rsp.done, "divider did not finish in 33 cycles")
  `RSE_CHECK(a_div_no_overlap, clk, rst, div_req.start, !div_rsp.done, "divider started while a quotient was returning")

endmodule

FILE: test/rpn_stack_evaluator_top_tb.sv
module rpn_stack_evaluator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int DEPTH = 16;
  localparam int SYMBOL_GOAL = 1800;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } expr_result_t;

  // Tracks operand stack and first error, queues the result of each expression.
  class rpn_result_tracker;
    logic [31:0]  stack_words[DEPTH];
    int unsigned  depth_used;
    status_t      first_err;
    expr_result_t pending_results[$];
    int unsigned  errors;

    function new();
      depth_used = 0;
      first_err = ST_OK;
      errors = 0;
    endfunction

    function void note_symbol(logic [7:0] sym, logic is_last);
      logic [31:0]  rhs;
      logic [31:0]  lhs;
      logic [31:0]  res;
      logic [31:0]  mag_n;
      logic [31:0]  mag_d;
      expr_result_t r;
      if (first_err == ST_OK) begin
        if (sym == CH_SPACE) begin
        end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
          if (depth_used >= DEPTH) begin
            first_err = ST_OVERFLOW;
          end else begin
            stack_words[depth_used] = {24'd0, sym - CH_ZERO};
            depth_used++;
          end
        end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
          if (depth_used < 2) begin
            first_err = ST_FEW;
          end else begin
            rhs = stack_words[depth_used - 1];
            lhs = stack_words[depth_used - 2];
            res = '0;
            if (sym == CH_PLUS) begin
              res = lhs + rhs;
            end else if (sym == CH_MINUS) begin
              res = lhs - rhs;
            end else if (sym == CH_STAR) begin
              res = lhs * rhs;
            end else if (rhs == 0) begin
              first_err = ST_DIVZERO;
            end else begin
              // magnitude divide, sign fixed after; min / -1 wraps to min
              mag_n = lhs[31] ? -lhs : lhs;
              mag_d = rhs[31] ? -rhs : rhs;
              res = mag_n / mag_d;
              if (lhs[31] != rhs[31]) begin
                res = -res;
              end
            end
            if (first_err == ST_OK) begin
              depth_used--;
              stack_words[depth_used - 1] = res;
            end
          end
        end else begin
          first_err = ST_BADCHAR;
        end
      end
      if (is_last) begin
        if (first_err != ST_OK) begin
          r.value = 0;
          r.status = first_err;
        end else if (depth_used != 1) begin
          r.value = 0;
          r.status = ST_NOTONE;
        end else begin
          r.value = stack_words[0];
          r.status = ST_OK;
        end
        pending_results.push_back(r);
        depth_used = 0;
        first_err = ST_OK;
      end
    endfunction

    function void check_result(logic signed [31:0] got_value, logic [2:0] got_status);
      expr_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d", $time, got_value, got_status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.value) begin
        $display("%0t: value mismatch, expected %0d, actual %0d", $time, want.value, got_value);
        errors++;
      end
      if (got_status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                 got_status);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rse_in_if  expr_ch();
  rse_out_if result_ch();

  rpn_stack_evaluator_top #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .expr(expr_ch.sink),
    .result(result_ch.source)
  );

  rpn_result_tracker tracker = new();

  logic [7:0]  expr_chars[$];
  int unsigned symbols_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_phase;
  int unsigned rx_stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // transaction monitors and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (expr_ch.valid && expr_ch.ready) begin
        tracker.note_symbol(expr_ch.symbol, expr_ch.last);
      end
      if (result_ch.valid && result_ch.ready) begin
        tracker.check_result(result_ch.value, result_ch.status);
      end
      if ((expr_ch.valid && expr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("rpn_stack_evaluator_top_tb: errors");
        $finish;
      end
    end
  end

  // receiver backpressure: one of four modes, redrawn at random intervals
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    rx_phase++;
    case (rx_mode)
      0: begin
        result_ch.ready = 1'b1;
      end
      1: begin
        result_ch.ready = 1'($urandom_range(0, 1));
      end
      2: begin
        result_ch.ready = (rx_phase % 3) == 0;
      end
      default: begin
        if (rx_stall_left > 0) begin
          result_ch.ready = 1'b0;
          rx_stall_left--;
        end else begin
          result_ch.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(5, 40);
          end
        end
      end
    endcase
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_symbol(input logic [7:0] sym, input logic is_last);
    if (burst_left == 0) begin
      expr_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    expr_ch.valid = 1'b1;
    expr_ch.symbol = sym;
    expr_ch.last = is_last;
    do @(posedge clk); while (!expr_ch.ready);
    @(negedge clk);
    burst_left--;
    symbols_sent++;
  endtask

  task automatic play_expression();
    for (int i = 0; i < expr_chars.size(); i++) begin
      send_symbol(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic wait_for_results();
    expr_ch.valid = 1'b0;
    while (tracker.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
    end
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // valid postfix expression with n_ops operators and random spacing
  function automatic void append_wellformed(int unsigned n_ops);
    int unsigned pushes_left = n_ops + 1;
    int unsigned on_stack = 0;
    while (pushes_left > 0 || on_stack > 1) begin
      if (pushes_left > 0 && (on_stack < 2 || (on_stack < DEPTH && $urandom_range(0, 1)))) begin
        expr_chars.push_back(random_digit());
        pushes_left--;
        on_stack++;
      end else begin
        expr_chars.push_back(random_op());
        on_stack--;
      end
      if ($urandom_range(0, 5) == 0) begin
        expr_chars.push_back(CH_SPACE);
      end
    end
  endfunction

  task automatic play_random_expression();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      append_wellformed($urandom_range(0, 9) == 0 ? $urandom_range(8, 15) : $urandom_range(0, 6));
    end else if (pick < 68) begin
      // overflow, then some trailing characters
      repeat ($urandom_range(DEPTH + 1, DEPTH + 3)) expr_chars.push_back(random_digit());
      repeat ($urandom_range(0, 3)) expr_chars.push_back(random_op());
    end else if (pick < 72) begin
      // 8^10 * 2 wraps to the most negative value, then divide or multiply by -1
      append_text("88*8*8*8*8*8*8*8*8*2*");
      append_text($urandom_range(0, 2) != 0 ? "01-/" : "01-*");
    end else if (pick < 86) begin
      append_wellformed($urandom_range(1, 6));
      idx = $urandom_range(0, expr_chars.size() - 1);
      case ($urandom_range(0, 3))
        0: expr_chars[idx] = 8'($urandom_range(0, 255));
        1: expr_chars[idx] = random_op();
        2: expr_chars.delete(idx);
        default: expr_chars.push_front(random_op());
      endcase
      if (expr_chars.size() == 0) begin
        expr_chars.push_back(CH_SPACE);
      end
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      // short and underfilled
      repeat ($urandom_range(0, 1)) expr_chars.push_back(random_digit());
      expr_chars.push_back(random_op());
      repeat ($urandom_range(0, 2)) expr_chars.push_back(CH_SPACE);
    end
    play_expression();
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    expr_ch.valid = 1'b0;
    expr_ch.symbol = '0;
    expr_ch.last = 1'b0;
    result_ch.ready = 1'b0;
    symbols_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    rx_mode = 0;
    rx_mode_left = 0;
    rx_phase = 0;
    rx_stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);

    append_text("3 4+");
    play_expression();
    append_text("59-");
    play_expression();
    append_text("78*3/");
    play_expression();
    append_text("5");
    expr_chars.push_back(8'hFF);
    play_expression();
    expr_chars.push_back(8'h00);
    play_expression();
    append_text("+");
    play_expression();
    append_text("50/");
    play_expression();
    append_text("12");
    play_expression();
    append_text(" ");
    play_expression();
    wait_for_results();

    while (symbols_sent < SYMBOL_GOAL) begin
      play_random_expression();
      if (!paused && symbols_sent > SYMBOL_GOAL / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    expr_ch.valid = 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.outstanding());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("rpn_stack_evaluator_top_tb: clean");
    end else begin
      $display("rpn_stack_evaluator_top_tb: errors");
    end
    $finish;
  end

endmodule
